FILE: rtl/invc_pkg.sv
// shared constants and token type for the inversion counter
package invc_pkg;

	localparam int MAX_ITEMS = 256;
	localparam int KEY_WIDTH = 32;
	localparam int KEY_W     = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
	localparam int CNT_W     = $clog2(MAX_ITEMS);
	localparam int TOT_W     = 15;
	localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

	typedef struct packed {
		logic             last;
		logic             placed;
		logic [CNT_W-1:0] cnt;
		logic [KEY_W-1:0] key;
	} invc_payload_t;

	typedef struct packed {
		logic          valid;
		invc_payload_t pl;
	} invc_token_t;

endpackage

FILE: rtl/invc_cell.sv
// one cell of the key chain: holds one stored key and counts greater keys for passing requests
module invc_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  invc_pkg::invc_token_t tin,
	output invc_pkg::invc_token_t tout
);
	import invc_pkg::*;

	logic             full_q;
	logic [KEY_W-1:0] key_q;
	logic             tok_valid_q;
	invc_payload_t    tok_q;
	invc_payload_t    nxt_pl;
	logic             take;

	assign take = tin.valid && !tin.pl.placed && !full_q;

	always_comb begin
		nxt_pl = tin.pl;
		if (full_q && !tin.pl.placed && ($signed(key_q) > $signed(tin.pl.key))) begin
			nxt_pl.cnt = tin.pl.cnt + {{(CNT_W-1){1'b0}}, 1'b1};
		end
		if (take) begin
			nxt_pl.placed = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q      <= 1'b0;
			tok_valid_q <= 1'b0;
		end else if (adv) begin
			tok_valid_q <= tin.valid;
			if (tin.valid && tin.pl.last) begin
				full_q <= 1'b0;
			end else if (take) begin
				full_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q <= nxt_pl;
			if (take) begin
				key_q <= tin.pl.key;
			end
		end
	end

	assign tout.valid = tok_valid_q;
	assign tout.pl    = tok_q;

	a_place: assert property (@(posedge clk) disable iff (!arst_n)
		adv && tin.valid && !tin.pl.placed && !full_q |=> tok_valid_q && tok_q.placed)
		else $error("empty cell did not take an unplaced request");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && tin.valid && tin.pl.last |=> !full_q)
		else $error("cell not cleared by closing request");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(full_q) && $stable(tok_valid_q))
		else $error("cell changed while chain stalled");

endmodule

FILE: rtl/invc_accum.sv
// end of chain: running total, overflow flag and result register
module invc_accum (
	input  logic                  clk,
	input  logic                  arst_n,
	input  invc_pkg::invc_token_t tail,
	output logic                  adv,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata  // [14:0] inversions, [15] overflow
);
	import invc_pkg::*;

	logic [TOT_W-1:0] total_q;
	logic             ovf_q;
	logic             out_valid_q;
	logic [TOT_W-1:0] out_inv_q;
	logic             out_ovf_q;
	logic [TOT_W:0]   sum;
	logic [TOT_W-1:0] nxt_total;
	logic             nxt_ovf;
	logic             emit;

	assign adv  = !(tail.valid && tail.pl.last && out_valid_q && !m_tready);
	assign emit = adv && tail.valid && tail.pl.last;

	always_comb begin
		sum       = {1'b0, total_q} + (TOT_W+1)'(tail.pl.cnt);
		nxt_total = total_q;
		nxt_ovf   = ovf_q;
		if (tail.valid) begin
			if (tail.pl.placed) begin
				nxt_total = sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];
			end else begin
				nxt_ovf = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				if (emit) begin
					total_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					total_q <= nxt_total;
					ovf_q   <= nxt_ovf;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_inv_q <= nxt_total;
			out_ovf_q <= nxt_ovf;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_ovf_q, out_inv_q};

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> m_tvalid && !m_tready)
		else $error("chain stalled without a blocked result");

	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		adv && tail.valid && tail.pl.last |=> m_tvalid && total_q == '0 && !ovf_q)
		else $error("closing request did not produce a result");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !(adv && tail.valid && tail.pl.last) |=> !m_tvalid)
		else $error("taken result not retired");

endmodule

FILE: rtl/inversion_counter_core.sv
// inversion counter top level: chain of key cells followed by the accumulator
//
//  channel | dir | fields
//  s_*     | in  | tdata[31:0] value (signed), tlast last
//  m_*     | out | tdata[14:0] inversions, tdata[15] overflow
//
// unless stalled, one request accepted per cycle and each request walks one cell a cycle
// m_tvalid rises once the closing request has passed every cell and reached the result register
// arst_n clears all cell valid flags, the total and the valid flag of the result register
// a result left waiting stalls the chain only when the next closing request reaches its end
module inversion_counter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [14:0] inversions, [15] overflow
);
	import invc_pkg::*;

	invc_token_t chain [MAX_ITEMS+1];
	logic        adv;

	assign s_tready           = adv;
	assign chain[0].valid     = s_tvalid;
	assign chain[0].pl.last   = s_tlast;
	assign chain[0].pl.placed = 1'b0;
	assign chain[0].pl.cnt    = '0;
	assign chain[0].pl.key    = s_tdata[KEY_W-1:0];

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		invc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.tin    (chain[i]),
			.tout   (chain[i+1])
		);
	end

	invc_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.tail     (chain[MAX_ITEMS]),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: tb/inversion_counter_core_tb.sv
// self-checking testbench for the inversion counter core
`timescale 1ns / 1ps

module inversion_counter_core_tb;
	import invc_pkg::*;

	localparam int RANDOM_ITEMS     = 750;
	localparam int LONG_HOLD_CYCLES = 1200;
	localparam int DRAIN_CYCLES     = MAX_ITEMS + 40;
	localparam int REPORT_LIMIT     = 40;

	typedef struct packed {
		logic [TOT_W-1:0] inversions;
		logic             overflow;
	} set_result_t;

	typedef struct packed {
		logic [31:0]      len;
		logic [31:0]      start_val;
		logic [31:0]      stride;
		logic             typed;
		logic [TOT_W-1:0] inversions;
		logic             overflow;
	} set_row_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	set_result_t pending_results[$];
	logic signed [KEY_W-1:0] seen_keys[$];
	int unsigned tally_total;
	bit          tally_overflow;

	int mismatch_count = 0;
	int results_taken  = 0;
	int items_accepted = 0;
	int overflow_sets  = 0;
	int peak_total     = 0;
	int input_stalls   = 0;
	int source_calm    = 0;
	int sink_calm      = 0;
	bit long_hold_done = 1'b0;

	set_row_t directed_sets[12] = '{
		'{32'd1,   32'h0000_0000, 32'h0000_0000, 1'b1, 15'd0,     1'b0},
		'{32'd1,   32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 15'd0,     1'b0},
		'{32'd2,   32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 15'd1,     1'b0},
		'{32'd2,   32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 15'd0,     1'b0},
		'{32'd3,   32'h0000_0005, 32'h0000_0000, 1'b1, 15'd0,     1'b0},
		'{32'd4,   32'h0000_0003, 32'hFFFF_FFFF, 1'b1, 15'd6,     1'b0},
		'{32'd5,   32'hFFFF_FFFE, 32'h0000_0001, 1'b1, 15'd0,     1'b0},
		'{32'd6,   32'h5555_5555, 32'h5555_5555, 1'b0, 15'd0,     1'b0},
		'{32'd256, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 15'd32640, 1'b0},
		'{32'd257, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 15'd32640, 1'b1},
		'{32'd260, 32'h8000_0000, 32'h0000_0001, 1'b1, 15'd0,     1'b1},
		'{32'd7,   32'hDEAD_BEEF, 32'h9E37_79B9, 1'b0, 15'd0,     1'b0}
	};

	inversion_counter_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [31:0] value
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // [14:0] inversions, [15] overflow
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("inversion_counter_core_tb failed");
		$finish;
	end

	always @(posedge clk) begin
		if (s_tvalid && !s_tready)
			input_stalls <= input_stalls + 1;
	end

	task automatic report_mismatch(input string what);
		if (mismatch_count < REPORT_LIMIT)
			$display("mismatch at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic int draw_gap(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0)
			calm_left = $urandom_range(20, 120);
		return $urandom_range(0, 9);
	endfunction

	task automatic tally_inversions(input logic [31:0] value, input logic closes,
			output bit closed, output set_result_t res);
		logic signed [KEY_W-1:0] key;
		int unsigned greater;
		key = value[KEY_W-1:0];
		greater = 0;
		closed = 1'b0;
		res = '0;
		if (seen_keys.size() < MAX_ITEMS) begin
			foreach (seen_keys[i])
				if (seen_keys[i] > key)
					greater++;
			seen_keys = {seen_keys, key};
			if (tally_total + greater > TOTAL_MAX)
				tally_total = TOTAL_MAX;
			else
				tally_total += greater;
		end else begin
			tally_overflow = 1'b1;
		end
		if (closes) begin
			closed = 1'b1;
			res.inversions = tally_total[TOT_W-1:0];
			res.overflow = tally_overflow;
			seen_keys.delete();
			tally_total = 0;
			tally_overflow = 1'b0;
		end
	endtask

	task automatic send_value(input logic [31:0] value, input logic closes, input bit typed,
			input set_result_t typed_res);
		int gap;
		bit closed;
		set_result_t res;
		gap = draw_gap(source_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tlast <= closes;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		items_accepted++;
		tally_inversions(value, closes, closed, res);
		if (closed) begin
			if (typed)
				res = typed_res;
			if (res.overflow)
				overflow_sets++;
			if (res.inversions > peak_total)
				peak_total = res.inversions;
			pending_results = {pending_results, res};
		end
	endtask

	function automatic logic [31:0] pick_value(input int mode, input int idx,
			input logic [31:0] base);
		case (mode)
			0: begin
				return $urandom;
			end
			1: begin
				return 32'($urandom_range(0, 6)) - 32'd3;
			end
			2: begin
				case ($urandom_range(0, 4))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					3: return 32'hFFFF_FFFF;
					default: return $urandom;
				endcase
			end
			default: begin
				return base - 32'(idx) * 32'($urandom_range(0, 3)) + 32'($urandom_range(0, 1));
			end
		endcase
	endfunction

	initial begin : result_sink
		int gap;
		logic [15:0] got;
		set_result_t want;
		@(posedge arst_n);
		forever begin
			if (!long_hold_done && results_taken == 6) begin
				long_hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = draw_gap(sink_calm);
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(negedge clk); while (!m_tvalid);
			got = m_tdata;
			@(posedge clk);
			results_taken++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %0d (%0d, %0b) arrived with no set closed",
					results_taken, got[14:0], got[15]));
			end else begin
				want = pending_results.pop_front();
				if (got[14:0] !== want.inversions)
					report_mismatch($sformatf("result %0d inversions %0d, expected %0d",
						results_taken, got[14:0], want.inversions));
				if (got[15] !== want.overflow)
					report_mismatch($sformatf("result %0d overflow %0b, expected %0b",
						results_taken, got[15], want.overflow));
			end
		end
	end

	initial begin : request_source
		set_row_t row;
		set_result_t typed_res;
		int len;
		int mode;
		int random_items;
		logic [31:0] base;
		seen_keys.delete();
		tally_total = 0;
		tally_overflow = 1'b0;
		random_items = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_sets[r]) begin
			row = directed_sets[r];
			typed_res.inversions = row.inversions;
			typed_res.overflow = row.overflow;
			for (int i = 0; i < int'(row.len); i++)
				send_value(row.start_val + 32'(i) * row.stride, i == int'(row.len) - 1,
					row.typed, typed_res);
		end

		typed_res = '0;
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 24) == 0)
				len = $urandom_range(MAX_ITEMS - 6, MAX_ITEMS + 14);
			else
				len = $urandom_range(1, 24);
			mode = $urandom_range(0, 3);
			base = $urandom;
			for (int i = 0; i < len; i++)
				send_value(pick_value(mode, i, base), i == len - 1, 1'b0, typed_res);
			random_items += len;
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d sets over %0d accepted values, %0d past capacity, peak count %0d",
			results_taken, items_accepted, overflow_sets, peak_total);
		$display("input held back for %0d cycles while results waited, %0d mismatches",
			input_stalls, mismatch_count);
		if (mismatch_count == 0)
			$display("inversion_counter_core_tb passed");
		else
			$display("inversion_counter_core_tb failed");
		$finish;
	end

endmodule
